>>> rtl/core/der_rsa_key_header_locator_top_defines.svh
// assertion macros for the der rsa key header locator
// used by der_rsa_key_header_locator_top; needs clk and arst_n in scope
`ifndef DER_RSA_KEY_HEADER_LOCATOR_TOP_DEFINES_SVH
`define DER_RSA_KEY_HEADER_LOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define DRKHL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRKHL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/drkhl_pkg.sv
// shared types, constants and tables for the der rsa key header locator
// no dependencies; used by the channel interfaces and the top level
package drkhl_pkg;

	localparam int OFFSET_BITS      = 16;
	localparam int MAX_LENGTH_BYTES = 4;

	localparam int DATA_W       = 8;
	localparam int KEY_OFFSET_W = 16;
	localparam int STATUS_W     = 2;
	localparam int ACC_W        = 8 * MAX_LENGTH_BYTES;
	localparam int LEN_CNT_W    = $clog2(MAX_LENGTH_BYTES + 1);
	localparam int CMP_W        = (ACC_W > OFFSET_BITS) ? ACC_W : OFFSET_BITS;
	localparam int OFF_EXT_W    = (OFFSET_BITS > KEY_OFFSET_W) ? OFFSET_BITS : KEY_OFFSET_W;
	localparam int ELEM_W       = 3;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic KEY_MODE_REG = 1'b0;

	localparam logic [ELEM_W-1:0] LAST_ELEM = 3'd4;

	localparam logic [DATA_W-1:0] TAG_SEQUENCE     = 8'h30;
	localparam logic [DATA_W-1:0] TAG_INTEGER      = 8'h02;
	localparam logic [DATA_W-1:0] TAG_BIT_STRING   = 8'h03;
	localparam logic [DATA_W-1:0] TAG_OCTET_STRING = 8'h04;

	localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TAG   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LARGE = 2'd3;

	localparam logic MODE_PUBLIC  = 1'b0;
	localparam logic MODE_PRIVATE = 1'b1;

	typedef enum logic [1:0] {
		ACT_HEADER,
		ACT_SKIP,
		ACT_ONE,
		ACT_DONE
	} act_t;

	// expected tag of each wrapper element
	function automatic logic [DATA_W-1:0] elem_tag(input logic mode,
		input logic [ELEM_W-1:0] elem);
		logic [DATA_W-1:0] tag;
		tag = TAG_SEQUENCE;
		case ({mode, elem})
			{MODE_PUBLIC, 3'd2}:  tag = TAG_BIT_STRING;
			{MODE_PRIVATE, 3'd1}: tag = TAG_INTEGER;
			{MODE_PRIVATE, 3'd3}: tag = TAG_OCTET_STRING;
			default:              tag = TAG_SEQUENCE;
		endcase
		return tag;
	endfunction

	// what to do once an element's length is known
	function automatic act_t elem_act(input logic mode, input logic [ELEM_W-1:0] elem);
		act_t act;
		act = ACT_DONE;
		case ({mode, elem})
			{MODE_PUBLIC, 3'd0}:  act = ACT_HEADER;
			{MODE_PUBLIC, 3'd1}:  act = ACT_SKIP;
			{MODE_PUBLIC, 3'd2}:  act = ACT_ONE;
			{MODE_PRIVATE, 3'd0}: act = ACT_HEADER;
			{MODE_PRIVATE, 3'd1}: act = ACT_SKIP;
			{MODE_PRIVATE, 3'd2}: act = ACT_SKIP;
			{MODE_PRIVATE, 3'd3}: act = ACT_HEADER;
			default:              act = ACT_DONE;
		endcase
		return act;
	endfunction

endpackage

>>> rtl/core/drkhl_byte_if.sv
// input channel: one key byte per word with buffer start and end marks
// depends on drkhl_pkg
interface drkhl_byte_if;
	logic                           valid;
	logic                           ready;
	logic [drkhl_pkg::DATA_W-1:0]   data_byte;
	logic                           first_byte;
	logic                           last_byte;

	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

>>> rtl/core/drkhl_result_if.sv
// result channel: key contents offset and status, one word per buffer
// depends on drkhl_pkg
interface drkhl_result_if;
	logic                                valid;
	logic                                ready;
	logic [drkhl_pkg::KEY_OFFSET_W-1:0]  key_offset;
	logic [drkhl_pkg::STATUS_W-1:0]      status;

	modport source (output valid, key_offset, status, input ready);
	modport sink (input valid, key_offset, status, output ready);
endinterface

>>> rtl/core/der_rsa_key_header_locator_top.sv
// channel      dir   word                                  handshake
// key_bytes    in    data_byte, first_byte, last_byte      valid/ready
// locate_result out  key_offset, status                    valid/ready
// apb          in    key_mode register at address 0        psel/penable, pready high
//
// one byte per cycle while the output register is free or being drained; a word is
// registered, parsed against the wrapper state, and the result lands in the output
// register; the parse step moves only while that register is free or being drained
// arst_n clears parse state, key_mode and both valid flags
//
// top level of the der rsa key header locator
// depends on drkhl_pkg, drkhl_byte_if, drkhl_result_if and the defines header
`include "der_rsa_key_header_locator_top_defines.svh"

module der_rsa_key_header_locator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	drkhl_byte_if.sink                          key_bytes,
	drkhl_result_if.source                      locate_result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [drkhl_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [drkhl_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [drkhl_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready
);

	typedef enum logic [1:0] {
		SUB_TAG,
		SUB_LEN0,
		SUB_LENX,
		SUB_SKIP
	} sub_t;

	// input stage
	logic                               valid_s1;
	logic [drkhl_pkg::DATA_W-1:0]       byte_s1;
	logic                               first_s1;
	logic                               last_s1;

	// parse state
	logic                               key_mode_q;
	logic [drkhl_pkg::ELEM_W-1:0]       elem_q;
	sub_t                               sub_q;
	logic [drkhl_pkg::OFFSET_BITS-1:0]  byte_pos_q;
	logic [drkhl_pkg::ACC_W-1:0]        len_acc_q;
	logic [drkhl_pkg::LEN_CNT_W-1:0]    len_left_q;
	logic [drkhl_pkg::OFFSET_BITS-1:0]  skip_q;
	logic                               finished_q;

	// output register
	logic                               out_valid_q;
	logic [drkhl_pkg::KEY_OFFSET_W-1:0] key_offset_q;
	logic [drkhl_pkg::STATUS_W-1:0]     status_q;

	logic out_free;
	logic fire_s1;
	logic take;
	logic cfg_write;

	// effective state after a restart
	logic [drkhl_pkg::ELEM_W-1:0]       cur_elem;
	sub_t                               cur_sub;
	logic [drkhl_pkg::OFFSET_BITS-1:0]  cur_pos;
	logic [drkhl_pkg::ACC_W-1:0]        cur_acc;
	logic [drkhl_pkg::LEN_CNT_W-1:0]    cur_left;
	logic [drkhl_pkg::OFFSET_BITS-1:0]  cur_skip;
	logic                               cur_fin;

	logic [drkhl_pkg::ELEM_W-1:0]       n_elem;
	logic [drkhl_pkg::ELEM_W-1:0]       elem_inc;
	sub_t                               n_sub;
	logic [drkhl_pkg::OFFSET_BITS-1:0]  next_pos;
	logic [drkhl_pkg::ACC_W-1:0]        n_acc;
	logic [drkhl_pkg::LEN_CNT_W-1:0]    n_left;
	logic [drkhl_pkg::OFFSET_BITS-1:0]  n_skip;
	logic [drkhl_pkg::CMP_W-1:0]        acc_ext;
	logic [drkhl_pkg::CMP_W-1:0]        room_ext;
	logic [drkhl_pkg::OFF_EXT_W-1:0]    off_ext;
	logic [drkhl_pkg::DATA_W-1:0]       exp_tag;
	drkhl_pkg::act_t                    act;
	logic                               pos_max;
	logic                               len_done;
	logic                               has_status;
	logic [drkhl_pkg::STATUS_W-1:0]     n_status;
	logic                               produce;

	assign out_free        = !out_valid_q || locate_result.ready;
	assign fire_s1         = valid_s1 && out_free;
	assign key_bytes.ready = !valid_s1 || out_free;
	assign take            = key_bytes.valid && key_bytes.ready;

	assign locate_result.valid      = out_valid_q;
	assign locate_result.key_offset = key_offset_q;
	assign locate_result.status     = status_q;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == drkhl_pkg::KEY_MODE_REG);

	always_comb begin
		prdata = '0;
		if (paddr[2] == drkhl_pkg::KEY_MODE_REG) begin
			prdata[0] = key_mode_q;
		end
	end

	always_comb begin
		if (first_s1) begin
			cur_elem = '0;
			cur_sub  = SUB_TAG;
			cur_pos  = '0;
			cur_acc  = '0;
			cur_left = '0;
			cur_skip = '0;
			cur_fin  = 1'b0;
		end else begin
			cur_elem = elem_q;
			cur_sub  = sub_q;
			cur_pos  = byte_pos_q;
			cur_acc  = len_acc_q;
			cur_left = len_left_q;
			cur_skip = skip_q;
			cur_fin  = finished_q;
		end
	end

	always_comb begin
		next_pos = cur_pos + 1'b1;
		pos_max  = (cur_pos == '1);
		exp_tag  = drkhl_pkg::elem_tag(key_mode_q, cur_elem);
		act      = drkhl_pkg::elem_act(key_mode_q, cur_elem);
		elem_inc = (cur_elem == drkhl_pkg::LAST_ELEM) ? cur_elem : cur_elem + 1'b1;

		n_elem     = cur_elem;
		n_sub      = cur_sub;
		n_acc      = cur_acc;
		n_left     = cur_left;
		n_skip     = cur_skip;
		len_done   = 1'b0;
		has_status = 1'b0;
		n_status   = drkhl_pkg::ST_FOUND;

		if (pos_max) begin
			has_status = 1'b1;
			n_status   = drkhl_pkg::ST_LARGE;
		end else begin
			case (cur_sub)
				SUB_TAG: begin
					if (byte_s1 != exp_tag) begin
						has_status = 1'b1;
						n_status   = drkhl_pkg::ST_TAG;
					end else begin
						n_sub = SUB_LEN0;
					end
				end
				SUB_LEN0: begin
					n_acc = '0;
					if (byte_s1[7]) begin
						if (byte_s1[6:0] > 7'(drkhl_pkg::MAX_LENGTH_BYTES)) begin
							has_status = 1'b1;
							n_status   = drkhl_pkg::ST_LARGE;
						end else if (byte_s1[6:0] == 7'd0) begin
							len_done = 1'b1;
						end else begin
							n_left = byte_s1[drkhl_pkg::LEN_CNT_W-1:0];
							n_sub  = SUB_LENX;
						end
					end else begin
						n_acc[7:0] = byte_s1;
						len_done   = 1'b1;
					end
				end
				SUB_LENX: begin
					n_acc      = cur_acc << 8;
					n_acc[7:0] = byte_s1;
					if (cur_left != '0) begin
						n_left = cur_left - 1'b1;
					end
					if (n_left == '0) begin
						len_done = 1'b1;
					end
				end
				default: begin
					if (cur_skip != '0) begin
						n_skip = cur_skip - 1'b1;
					end
					if (n_skip == '0) begin
						n_elem = elem_inc;
						n_sub  = SUB_TAG;
					end
				end
			endcase
		end

		acc_ext  = '0;
		acc_ext[drkhl_pkg::ACC_W-1:0] = n_acc;
		room_ext = '0;
		room_ext[drkhl_pkg::OFFSET_BITS-1:0] = ~next_pos;

		if (!has_status && len_done) begin
			case (act)
				drkhl_pkg::ACT_HEADER: begin
					n_elem = elem_inc;
					n_sub  = SUB_TAG;
				end
				drkhl_pkg::ACT_SKIP: begin
					if (n_acc == '0) begin
						n_elem = elem_inc;
						n_sub  = SUB_TAG;
					end else if (acc_ext > room_ext) begin
						has_status = 1'b1;
						n_status   = drkhl_pkg::ST_LARGE;
					end else begin
						n_skip = acc_ext[drkhl_pkg::OFFSET_BITS-1:0];
						n_sub  = SUB_SKIP;
					end
				end
				drkhl_pkg::ACT_ONE: begin
					n_skip = '0;
					n_skip[0] = 1'b1;
					n_sub  = SUB_SKIP;
				end
				default: begin
					has_status = 1'b1;
					n_status   = drkhl_pkg::ST_FOUND;
				end
			endcase
		end

		if (!has_status && last_s1) begin
			has_status = 1'b1;
			n_status   = drkhl_pkg::ST_SHORT;
		end

		produce = !cur_fin && has_status;
		off_ext = '0;
		off_ext[drkhl_pkg::OFFSET_BITS-1:0] = next_pos;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			key_mode_q  <= 1'b0;
			elem_q      <= '0;
			sub_q       <= SUB_TAG;
			byte_pos_q  <= '0;
			len_acc_q   <= '0;
			len_left_q  <= '0;
			skip_q      <= '0;
			finished_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				key_mode_q <= pwdata[0];
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1 && !cur_fin) begin
				elem_q     <= n_elem;
				sub_q      <= n_sub;
				byte_pos_q <= next_pos;
				len_acc_q  <= n_acc;
				len_left_q <= n_left;
				skip_q     <= n_skip;
				finished_q <= has_status;
			end
			if (fire_s1 && produce) begin
				out_valid_q <= 1'b1;
			end else if (locate_result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1  <= key_bytes.data_byte;
			first_s1 <= key_bytes.first_byte;
			last_s1  <= key_bytes.last_byte;
		end
		if (fire_s1 && produce) begin
			status_q     <= n_status;
			key_offset_q <= (n_status == drkhl_pkg::ST_FOUND) ?
				off_ext[drkhl_pkg::KEY_OFFSET_W-1:0] : '0;
		end
	end

	`DRKHL_ASSERT_NOW(a_err_offset_zero, locate_result.valid && (locate_result.status != drkhl_pkg::ST_FOUND), locate_result.key_offset == '0, "error word carries a nonzero offset")
	`DRKHL_ASSERT_NEXT(a_result_finishes, fire_s1 && produce, finished_q, "result given but parse not finished")
	`DRKHL_ASSERT_NOW(a_lenx_count, !finished_q && (sub_q == SUB_LENX), len_left_q != '0, "length byte count empty in long form")
	`DRKHL_ASSERT_NOW(a_skip_count, !finished_q && (sub_q == SUB_SKIP), skip_q != '0, "skip count empty while skipping")

endmodule

>>> verif/der_rsa_key_header_locator_checker.sv
`timescale 1ns / 100ps
// checker for the der rsa key header locator: follows the key_mode register and the
// byte words, predicts the located offset or status of each buffer and compares results
// depends on drkhl_pkg, drkhl_byte_if and drkhl_result_if
module der_rsa_key_header_locator_checker #(
	parameter logic [drkhl_pkg::APB_ADDR_W-1:0] KEY_MODE_ADDR = '0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	drkhl_byte_if                               key_bytes,
	drkhl_result_if                             locate_result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [drkhl_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [drkhl_pkg::APB_DATA_W-1:0]    pwdata,
	input  logic [drkhl_pkg::APB_DATA_W-1:0]    prdata,
	input  logic                                pready,
	output int                                  mismatches,
	output int                                  outstanding
);
	import drkhl_pkg::*;

	localparam longint unsigned OFFSET_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
	localparam int REPORT_LIMIT = 10;

	typedef enum bit [1:0] {
		AT_TAG,
		AT_LEN,
		AT_LEN_EXT,
		AT_CONTENT
	} field_t;

	typedef struct packed {
		logic [KEY_OFFSET_W-1:0] key_offset;
		logic [STATUS_W-1:0]     status;
	} locate_word_t;

	bit              key_mode_q;
	int unsigned     walk_elem;
	field_t          walk_field;
	longint unsigned walk_pos;
	longint unsigned len_acc;
	int unsigned     len_left;
	longint unsigned skip_left;
	bit              walk_done;
	int              errors;
	locate_word_t    located_q[$];
	locate_word_t    oldest;

	function automatic logic [DATA_W-1:0] wanted_tag(input bit mode, input int unsigned e);
		logic [DATA_W-1:0] tag;
		tag = TAG_SEQUENCE;
		if (mode == MODE_PUBLIC && e == 2)
			tag = TAG_BIT_STRING;
		if (mode == MODE_PRIVATE && e == 1)
			tag = TAG_INTEGER;
		if (mode == MODE_PRIVATE && e == 3)
			tag = TAG_OCTET_STRING;
		return tag;
	endfunction

	// what a wrapper element needs once its length is decoded
	function automatic act_t element_work(input bit mode, input int unsigned e);
		act_t act;
		case (e)
			0: act = ACT_HEADER;
			1: act = ACT_SKIP;
			2: act = (mode == MODE_PUBLIC) ? ACT_ONE : ACT_SKIP;
			3: act = (mode == MODE_PUBLIC) ? ACT_DONE : ACT_HEADER;
			default: act = ACT_DONE;
		endcase
		return act;
	endfunction

	task automatic restart_walk();
		walk_elem  = 0;
		walk_field = AT_TAG;
		walk_pos   = 0;
		len_acc    = 0;
		len_left   = 0;
		skip_left  = 0;
		walk_done  = 1'b0;
	endtask

	task automatic flag_mismatch(input string what);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%0t: locate mismatch: %s", $time, what);
	endtask

	task automatic walk_key_byte(input logic [DATA_W-1:0] b, input logic first, input logic last);
		longint unsigned nxt;
		int unsigned     e;
		field_t          f;
		act_t            act;
		bit              len_done;
		int              st;
		locate_word_t    word;
		st = -1;
		len_done = 1'b0;
		if (first)
			restart_walk();
		if (walk_done)
			return;
		nxt = walk_pos + 1;
		e = walk_elem;
		f = walk_field;
		act = element_work(key_mode_q, e);
		if (nxt > OFFSET_MAX) begin
			st = ST_LARGE;
		end else begin
			case (f)
				AT_TAG: begin
					if (b != wanted_tag(key_mode_q, e))
						st = ST_TAG;
					else
						f = AT_LEN;
				end
				AT_LEN: begin
					if (b[7]) begin
						len_acc = 0;
						if (b[6:0] > MAX_LENGTH_BYTES) begin
							st = ST_LARGE;
						end else if (b[6:0] == 0) begin
							len_done = 1'b1;
						end else begin
							len_left = b[6:0];
							f = AT_LEN_EXT;
						end
					end else begin
						len_acc = b;
						len_done = 1'b1;
					end
				end
				AT_LEN_EXT: begin
					len_acc = (len_acc << 8) | b;
					if (len_left > 0)
						len_left--;
					if (len_left == 0)
						len_done = 1'b1;
				end
				default: begin
					if (skip_left > 0)
						skip_left--;
					if (skip_left == 0) begin
						e++;
						f = AT_TAG;
					end
				end
			endcase
		end
		if (st < 0 && len_done) begin
			case (act)
				ACT_HEADER: begin
					e++;
					f = AT_TAG;
				end
				ACT_SKIP: begin
					if (len_acc == 0) begin
						e++;
						f = AT_TAG;
					end else if (len_acc > OFFSET_MAX - nxt) begin
						st = ST_LARGE;
					end else begin
						skip_left = len_acc;
						f = AT_CONTENT;
					end
				end
				ACT_ONE: begin
					skip_left = 1;
					f = AT_CONTENT;
				end
				default: st = ST_FOUND;
			endcase
		end
		if (e > int'(LAST_ELEM))
			e = int'(LAST_ELEM);
		walk_elem = e;
		walk_field = f;
		walk_pos = nxt;
		if (st < 0 && last)
			st = ST_SHORT;
		if (st >= 0) begin
			walk_done = 1'b1;
			word.key_offset = (st == int'(ST_FOUND)) ? nxt[KEY_OFFSET_W-1:0] : '0;
			word.status = st[STATUS_W-1:0];
			located_q.push_back(word);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mode_q = MODE_PUBLIC;
			restart_walk();
			located_q.delete();
			mismatches <= errors;
			outstanding <= 0;
		end else begin
			if (locate_result.valid && locate_result.ready) begin
				if (located_q.size() == 0) begin
					flag_mismatch($sformatf("no result expected, got offset %0d status %0d",
						locate_result.key_offset, locate_result.status));
				end else begin
					oldest = located_q.pop_front();
					if (oldest.key_offset !== locate_result.key_offset ||
						oldest.status !== locate_result.status)
						flag_mismatch($sformatf(
							"expected offset %0d status %0d, got offset %0d status %0d",
							oldest.key_offset, oldest.status,
							locate_result.key_offset, locate_result.status));
				end
			end
			if (key_bytes.valid && key_bytes.ready)
				walk_key_byte(key_bytes.data_byte, key_bytes.first_byte, key_bytes.last_byte);
			if (psel && penable && pready && paddr == KEY_MODE_ADDR) begin
				if (pwrite) begin
					key_mode_q = pwdata[0];
				end else if (prdata !== APB_DATA_W'(key_mode_q)) begin
					flag_mismatch($sformatf("key_mode read expected %0h, got %0h",
						key_mode_q, prdata));
				end
			end
			mismatches <= errors;
			outstanding <= located_q.size();
		end
	end

endmodule

>>> verif/der_rsa_key_header_locator_top_tb.sv
`timescale 1ns / 100ps
// testbench top for the der rsa key header locator: drives key byte buffers, the
// receiver handshake and key_mode writes; der_rsa_key_header_locator_checker judges
// depends on drkhl_pkg, both channel interfaces, the checker and the top level
module der_rsa_key_header_locator_top_tb;
	import drkhl_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam longint CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 150;
	localparam logic [DATA_W-1:0] LONG_FORM = 8'h80;
	localparam logic [APB_ADDR_W-1:0] KEY_MODE_ADDR = APB_ADDR_W'(4 * KEY_MODE_REG);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int          mismatches;
	int          outstanding;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        hold_arm = 1'b0;
	int          hold_left = 0;
	bit          hold_used = 1'b0;
	longint      cycles = 0;
	int          items_sent = 0;
	logic        cur_mode = MODE_PUBLIC;
	logic [DATA_W-1:0] der_bytes[$];

	drkhl_byte_if   key_bytes();
	drkhl_result_if locate_result();

	der_rsa_key_header_locator_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.key_bytes     (key_bytes),
		.locate_result (locate_result),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	der_rsa_key_header_locator_checker #(.KEY_MODE_ADDR(KEY_MODE_ADDR)) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.key_bytes     (key_bytes),
		.locate_result (locate_result),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[der_rsa_key_header_locator_top] ERROR");
			$finish;
		end
	end

	// result receiver, with one long hold-off once armed
	always @(posedge clk) begin
		if (hold_left != 0) begin
			locate_result.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_used) begin
			locate_result.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else begin
			locate_result.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_byte(input logic [DATA_W-1:0] d, input logic f, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			key_bytes.valid <= 1'b0;
			@(posedge clk);
		end
		key_bytes.valid <= 1'b1;
		key_bytes.data_byte <= d;
		key_bytes.first_byte <= f;
		key_bytes.last_byte <= l;
		do @(posedge clk); while (!key_bytes.ready);
	endtask

	task automatic send_bytes(input bit with_first, input int last_at);
		for (int i = 0; i < der_bytes.size(); i++) begin
			push_byte(der_bytes[i], with_first && i == 0, i == last_at);
			items_sent++;
		end
	endtask

	task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= KEY_MODE_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_key_mode(input logic mode);
		logic [APB_DATA_W-1:0] word;
		word = $urandom;
		word[0] = mode;
		apb_access(1'b1, word);
		apb_access(1'b0, $urandom);
		psel <= 1'b0;
		penable <= 1'b0;
		cur_mode = mode;
	endtask

	task automatic settle();
		key_bytes.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic longint unsigned random_len();
		case ($urandom_range(3))
			0: return $urandom_range(127);
			1: return $urandom_range(65535, 128);
			2: return $urandom;
			default: return $urandom_range(3);
		endcase
	endfunction

	function automatic longint unsigned skip_len();
		if ($urandom_range(24) == 0)
			return $urandom_range(300, 100);
		return $urandom_range(6);
	endfunction

	task automatic add_content(input longint unsigned n);
		repeat (n) der_bytes.push_back(DATA_W'($urandom));
	endtask

	task automatic add_length(input longint unsigned len);
		int nmin;
		int n;
		if (len < 128 && $urandom_range(2) != 0) begin
			der_bytes.push_back(len[DATA_W-1:0]);
		end else begin
			nmin = 1;
			while (nmin < MAX_LENGTH_BYTES && (len >> (8 * nmin)) != 0)
				nmin++;
			n = $urandom_range(MAX_LENGTH_BYTES, nmin);
			der_bytes.push_back(LONG_FORM | DATA_W'(n));
			for (int i = n - 1; i >= 0; i--)
				der_bytes.push_back(DATA_W'(len >> (8 * i)));
		end
	endtask

	// exact: the length is used to skip content, so only zero may go indefinite
	task automatic add_header(input logic [DATA_W-1:0] tag, input longint unsigned len,
		input bit exact);
		der_bytes.push_back(tag);
		if ((!exact || len == 0) && $urandom_range(5) == 0)
			der_bytes.push_back(LONG_FORM);
		else
			add_length(len);
	endtask

	task automatic build_wrapper(input logic mode);
		longint unsigned l1;
		longint unsigned l2;
		der_bytes.delete();
		add_header(TAG_SEQUENCE, random_len(), 1'b0);
		l1 = skip_len();
		if (mode == MODE_PUBLIC) begin
			add_header(TAG_SEQUENCE, l1, 1'b1);
			add_content(l1);
			add_header(TAG_BIT_STRING, random_len(), 1'b0);
			add_content(1);
		end else begin
			add_header(TAG_INTEGER, l1, 1'b1);
			add_content(l1);
			l2 = skip_len();
			add_header(TAG_SEQUENCE, l2, 1'b1);
			add_content(l2);
			add_header(TAG_OCTET_STRING, random_len(), 1'b0);
		end
		add_header(TAG_SEQUENCE, random_len(), 1'b0);
		add_content($urandom_range(3));
	endtask

	task automatic random_buffers(input int count);
		int start;
		int kind;
		int last_at;
		bit with_first;
		start = items_sent;
		while (items_sent - start < count) begin
			kind = $urandom_range(99);
			with_first = ($urandom_range(14) != 0);
			build_wrapper((kind >= 70 && kind < 78) ? !cur_mode : cur_mode);
			last_at = ($urandom_range(4) == 0) ? -1 : der_bytes.size() - 1;
			if (kind >= 78 && kind < 86) begin
				// buffer cut short
				last_at = $urandom_range(der_bytes.size() - 2);
				while (der_bytes.size() > last_at + 1)
					void'(der_bytes.pop_back());
			end else if (kind >= 86 && kind < 92) begin
				der_bytes[$urandom_range(der_bytes.size() - 1)] ^= DATA_W'($urandom_range(255, 1));
			end else if (kind >= 92 && kind < 96) begin
				der_bytes[1] = LONG_FORM | DATA_W'($urandom_range(127, MAX_LENGTH_BYTES + 1));
			end else if (kind >= 96) begin
				der_bytes.delete();
				add_content($urandom_range(8, 1));
				last_at = $urandom_range(1) ? int'($urandom_range(der_bytes.size() - 1)) : -1;
			end
			send_bytes(with_first, last_at);
		end
	endtask

	initial begin
		int send_pct[3];
		int recv_pct[3];
		send_pct = '{8, 77, 0};
		recv_pct = '{77, 8, 0};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		key_bytes.valid = 1'b0;
		key_bytes.data_byte = '0;
		key_bytes.first_byte = 1'b0;
		key_bytes.last_byte = 1'b0;
		locate_result.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 8;
		recv_idle_pct <= 77;

		// public wrapper straight out of reset, no first mark
		der_bytes = '{TAG_SEQUENCE, LONG_FORM, TAG_SEQUENCE, 8'h00, TAG_BIT_STRING, 8'h00, 8'h00,
			TAG_SEQUENCE, LONG_FORM};
		send_bytes(1'b0, 8);
		// wrong outer tag, then a byte that must be ignored
		der_bytes = '{8'h31, 8'hFF};
		send_bytes(1'b1, 1);
		// too many length bytes
		der_bytes = '{TAG_SEQUENCE, 8'h85};
		send_bytes(1'b1, -1);
		// ends inside a long-form length
		der_bytes = '{TAG_SEQUENCE, 8'h82, 8'h01};
		send_bytes(1'b1, 2);
		// skip length past the offset limit
		der_bytes = '{TAG_SEQUENCE, 8'h81, 8'hFF, TAG_SEQUENCE, 8'h82, 8'hFF, 8'hFF};
		send_bytes(1'b1, -1);
		// long forms on every sequence, unused-bits byte all ones
		der_bytes = '{TAG_SEQUENCE, 8'h84, 8'h00, 8'h00, 8'h00, 8'h10, TAG_SEQUENCE, 8'h81,
			8'h02, 8'hAA, 8'hBB, TAG_BIT_STRING, 8'h01, 8'hFF, TAG_SEQUENCE, 8'h84, 8'hFF,
			8'hFF, 8'hFF, 8'hFF};
		send_bytes(1'b1, 19);
		settle();

		set_key_mode(MODE_PRIVATE);
		der_bytes = '{TAG_SEQUENCE, LONG_FORM, TAG_INTEGER, 8'h01, 8'h00, TAG_SEQUENCE, LONG_FORM,
			TAG_OCTET_STRING, LONG_FORM, TAG_SEQUENCE, 8'h82, 8'h12, 8'h34};
		send_bytes(1'b1, 12);
		// mode switched halfway through a buffer
		der_bytes = '{TAG_SEQUENCE, LONG_FORM, TAG_INTEGER, 8'h01, 8'h00};
		send_bytes(1'b1, -1);
		settle();
		set_key_mode(MODE_PUBLIC);
		der_bytes = '{TAG_BIT_STRING, 8'h00, 8'h5A, TAG_SEQUENCE, 8'h00};
		send_bytes(1'b0, 4);
		settle();

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = send_pct[p];
			recv_idle_pct <= recv_pct[p];
			if (p == 2)
				hold_arm <= 1'b1;
			set_key_mode(MODE_PUBLIC);
			random_buffers(PHASE_ITEMS);
			settle();
			set_key_mode(MODE_PRIVATE);
			random_buffers(PHASE_ITEMS);
			settle();
		end

		if (mismatches == 0)
			$display("[der_rsa_key_header_locator_top] OK");
		else
			$display("[der_rsa_key_header_locator_top] ERROR");
		$finish;
	end

endmodule
